FILE: src/idnl_pkg.sv
`timescale 1ns / 1ps

package idnl_pkg;

    localparam int MAX_LEXEME_DEF = 64;
    localparam int RES_DEPTH_DEF  = 4;
    localparam int LEN_W          = 7;
    localparam int LINE_W         = 16;

    localparam logic [7:0] CH_TILDE      = 8'h7E;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_COMMENT = 2'd1,
        MODE_IDENT   = 2'd2,
        MODE_NUMBER  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        EV_ID_CHAR  = 2'd0,
        EV_NUM_CHAR = 2'd1,
        EV_ID_END   = 2'd2,
        EV_NUM_END  = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_DOUBLE_US  = 2'd1,
        ERR_TRAILING   = 2'd2,
        ERR_TOO_LONG   = 2'd3
    } t_err;

    typedef struct packed {
        t_event              ev;
        logic [7:0]          ch;
        logic [LEN_W-1:0]    len;
        logic [LINE_W-1:0]   line;
        t_err                err;
        logic                last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_step;

endpackage

FILE: src/identifier_number_lexer_core.sv
`timescale 1ns / 1ps
// Path: a character request is captured in the input register at the edge that accepts it, is
// scanned once the result queue has room for two results, and its results enter that queue.
// Throughput: one character per cycle while the result queue has room for two results; a character
// that yields two results (a token end and a new character) writes both; the queue sets the rate.
// Reset is synchronous and active low: scanner idle, line counter at one, queue empty.

module identifier_number_lexer_core #(
    parameter int MAX_LEXEME = idnl_pkg::MAX_LEXEME_DEF,
    parameter int RES_DEPTH  = idnl_pkg::RES_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_char_in,
    input  logic                            i_end_of_text,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [1:0]                      o_event_res,
    output logic [7:0]                      o_char_out,
    output logic [idnl_pkg::LEN_W-1:0]      o_token_length,
    output logic [idnl_pkg::LINE_W-1:0]     o_line_number,
    output logic [1:0]                      o_error_code,
    output logic                            o_last
);

    logic               r_in_valid;
    logic [7:0]         r_char;
    logic               r_eot;
    logic               w_room2;
    logic               w_step;
    idnl_pkg::t_step    w_scan;
    idnl_pkg::t_result  w_head;

    assign w_step     = r_in_valid && w_room2;
    assign o_in_ready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_char <= i_char_in;
            r_eot  <= i_end_of_text;
        end
    end

    idnl_scan #(
        .MAX_LEXEME (MAX_LEXEME)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_char  (r_char),
        .i_eot   (r_eot),
        .o_step  (w_scan)
    );

    idnl_res_fifo #(
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (w_step ? w_scan.count : 2'd0),
        .i_data0    (w_scan.first),
        .i_data1    (w_scan.second),
        .o_room2    (w_room2),
        .o_valid    (o_out_valid),
        .o_data     (w_head),
        .i_ready    (i_out_ready)
    );

    assign o_event_res    = w_head.ev;
    assign o_char_out     = w_head.ch;
    assign o_token_length = w_head.len;
    assign o_line_number  = w_head.line;
    assign o_error_code   = w_head.err;
    assign o_last         = w_head.last;

endmodule

FILE: src/idnl_scan.sv
`timescale 1ns / 1ps

module idnl_scan #(
    parameter int MAX_LEXEME = idnl_pkg::MAX_LEXEME_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_char,
    input  logic               i_eot,
    output idnl_pkg::t_step    o_step
);

    localparam logic [idnl_pkg::LEN_W-1:0] MAX_LEN = idnl_pkg::LEN_W'(MAX_LEXEME);
    localparam logic [idnl_pkg::LINE_W-1:0] LINE_MAX = '1;

    idnl_pkg::t_mode                r_mode, n_mode;
    logic [idnl_pkg::LINE_W-1:0]    r_line, n_line;
    logic [idnl_pkg::LEN_W-1:0]     r_len, n_len;
    logic                           r_us, n_us;
    logic                           r_ovf, n_ovf;

    logic                           w_letter, w_digit, w_us, w_nl, w_tilde, w_keep_ok;
    idnl_pkg::t_mode                w_idle_mode;

    logic                           e_valid;
    logic [idnl_pkg::LEN_W-1:0]     e_len;
    idnl_pkg::t_err                 e_err;
    logic                           c_valid;
    logic                           c_first;
    logic                           idle_pass;
    logic                           line_inc;
    idnl_pkg::t_result              c_res, e_res;
    logic                           first_is_char;

    assign w_letter  = (i_char >= 8'h41 && i_char <= 8'h5A) ||
                       (i_char >= 8'h61 && i_char <= 8'h7A);
    assign w_digit   = (i_char >= 8'h30 && i_char <= 8'h39);
    assign w_us      = (i_char == idnl_pkg::CH_UNDERSCORE);
    assign w_nl      = (i_char == idnl_pkg::CH_NEWLINE);
    assign w_tilde   = (i_char == idnl_pkg::CH_TILDE);
    assign w_keep_ok = (r_len < MAX_LEN);

    always_comb begin
        if (w_tilde) begin
            w_idle_mode = idnl_pkg::MODE_COMMENT;
        end else if (w_digit) begin
            w_idle_mode = idnl_pkg::MODE_NUMBER;
        end else if (w_letter) begin
            w_idle_mode = idnl_pkg::MODE_IDENT;
        end else begin
            w_idle_mode = idnl_pkg::MODE_IDLE;
        end
    end

    always_comb begin
        n_mode = r_mode;
        if (i_eot) begin
            n_mode = idnl_pkg::MODE_IDLE;
        end else begin
            case (r_mode)
                idnl_pkg::MODE_COMMENT: begin
                    if (w_nl) begin
                        n_mode = idnl_pkg::MODE_IDLE;
                    end
                end
                idnl_pkg::MODE_IDENT: begin
                    if (w_us && r_us) begin
                        n_mode = idnl_pkg::MODE_IDLE;
                    end else if (!(w_letter || w_digit || w_us)) begin
                        n_mode = w_idle_mode;
                    end
                end
                idnl_pkg::MODE_NUMBER: begin
                    if (!w_digit) begin
                        n_mode = w_idle_mode;
                    end
                end
                default: begin
                    n_mode = w_idle_mode;
                end
            endcase
        end
    end

    always_comb begin
        n_len     = r_len;
        n_us      = r_us;
        n_ovf     = r_ovf;
        e_valid   = 1'b0;
        e_len     = r_len;
        e_err     = idnl_pkg::ERR_NONE;
        c_valid   = 1'b0;
        c_first   = 1'b0;
        idle_pass = 1'b0;
        line_inc  = 1'b0;
        if (i_eot) begin
            if (r_mode == idnl_pkg::MODE_IDENT || r_mode == idnl_pkg::MODE_NUMBER) begin
                e_valid = 1'b1;
                if (r_ovf) begin
                    e_err = idnl_pkg::ERR_TOO_LONG;
                end else if (r_mode == idnl_pkg::MODE_IDENT && r_us) begin
                    e_err = idnl_pkg::ERR_TRAILING;
                end
            end
            n_len = '0;
            n_us  = 1'b0;
            n_ovf = 1'b0;
        end else begin
            case (r_mode)
                idnl_pkg::MODE_COMMENT: begin
                    line_inc = w_nl;
                end
                idnl_pkg::MODE_IDENT: begin
                    if (w_us && r_us) begin
                        c_first = 1'b1;
                        c_valid = w_keep_ok;
                        e_valid = 1'b1;
                        e_len   = w_keep_ok ? r_len + idnl_pkg::LEN_W'(1) : r_len;
                        e_err   = (r_ovf || !w_keep_ok) ? idnl_pkg::ERR_TOO_LONG
                                                        : idnl_pkg::ERR_DOUBLE_US;
                        n_len   = '0;
                        n_us    = 1'b0;
                        n_ovf   = 1'b0;
                    end else if (w_letter || w_digit || w_us) begin
                        if (w_keep_ok) begin
                            c_valid = 1'b1;
                            n_len   = r_len + idnl_pkg::LEN_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                        n_us = w_us;
                    end else begin
                        e_valid = 1'b1;
                        if (r_ovf) begin
                            e_err = idnl_pkg::ERR_TOO_LONG;
                        end else if (r_us) begin
                            e_err = idnl_pkg::ERR_TRAILING;
                        end
                        idle_pass = 1'b1;
                    end
                end
                idnl_pkg::MODE_NUMBER: begin
                    if (w_digit) begin
                        if (w_keep_ok) begin
                            c_valid = 1'b1;
                            n_len   = r_len + idnl_pkg::LEN_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else begin
                        e_valid = 1'b1;
                        if (r_ovf) begin
                            e_err = idnl_pkg::ERR_TOO_LONG;
                        end
                        idle_pass = 1'b1;
                    end
                end
                default: begin
                    idle_pass = 1'b1;
                end
            endcase
            if (idle_pass) begin
                n_len = '0;
                n_us  = 1'b0;
                n_ovf = 1'b0;
                if (w_nl) begin
                    line_inc = 1'b1;
                end else if (w_letter || w_digit) begin
                    c_valid = 1'b1;
                    n_len   = idnl_pkg::LEN_W'(1);
                end
            end
        end
        n_line = (line_inc && r_line != LINE_MAX) ? r_line + idnl_pkg::LINE_W'(1) : r_line;
    end

    always_comb begin
        c_res      = '0;
        c_res.ch   = i_char;
        c_res.line = r_line;
        c_res.err  = idnl_pkg::ERR_NONE;
        if (idle_pass) begin
            c_res.ev = w_digit ? idnl_pkg::EV_NUM_CHAR : idnl_pkg::EV_ID_CHAR;
        end else begin
            c_res.ev = (r_mode == idnl_pkg::MODE_IDENT) ? idnl_pkg::EV_ID_CHAR
                                                        : idnl_pkg::EV_NUM_CHAR;
        end
        e_res      = '0;
        e_res.ev   = (r_mode == idnl_pkg::MODE_IDENT) ? idnl_pkg::EV_ID_END
                                                      : idnl_pkg::EV_NUM_END;
        e_res.len  = e_len;
        e_res.line = r_line;
        e_res.err  = e_err;

        first_is_char       = c_valid && (c_first || !e_valid);
        o_step.count        = {1'b0, c_valid} + {1'b0, e_valid};
        o_step.first        = first_is_char ? c_res : e_res;
        o_step.second       = first_is_char ? e_res : c_res;
        o_step.first.last   = !(c_valid && e_valid);
        o_step.second.last  = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= idnl_pkg::MODE_IDLE;
            r_line <= idnl_pkg::LINE_W'(1);
            r_len  <= '0;
            r_us   <= 1'b0;
            r_ovf  <= 1'b0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_line <= n_line;
            r_len  <= n_len;
            r_us   <= n_us;
            r_ovf  <= n_ovf;
        end
    end

endmodule

FILE: src/idnl_res_fifo.sv
`timescale 1ns / 1ps

module idnl_res_fifo #(
    parameter int DEPTH = idnl_pkg::RES_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [1:0]          i_push_cnt,
    input  idnl_pkg::t_result   i_data0,
    input  idnl_pkg::t_result   i_data1,
    output logic                o_room2,
    output logic                o_valid,
    output idnl_pkg::t_result   o_data,
    input  logic                i_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    idnl_pkg::t_result  r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [PTR_W-1:0]   w_wr1;
    logic               w_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign w_wr1   = ptr_inc(r_wr);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign w_pop   = o_valid && i_ready;
    assign o_room2 = (r_count <= CNT_W'(DEPTH - 2));

    always_comb begin
        case (i_push_cnt)
            2'd1:    n_wr = w_wr1;
            2'd2:    n_wr = ptr_inc(w_wr1);
            default: n_wr = r_wr;
        endcase
        n_rd    = w_pop ? ptr_inc(r_rd) : r_rd;
        n_count = r_count + CNT_W'(i_push_cnt) - CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_data0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[w_wr1] <= i_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

FILE: src/idnl_checker.sv
`timescale 1ns / 1ps

module idnl_checker #(
    parameter int MAX_LEXEME = idnl_pkg::MAX_LEXEME_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [1:0]                   o_event_res,
    input logic [7:0]                   o_char_out,
    input logic [idnl_pkg::LEN_W-1:0]   o_token_length,
    input logic [idnl_pkg::LINE_W-1:0]  o_line_number,
    input logic [1:0]                   o_error_code
);

    logic w_char_ev;
    logic w_end_ev;

    assign w_char_ev = o_out_valid && (o_event_res == idnl_pkg::EV_ID_CHAR ||
                                       o_event_res == idnl_pkg::EV_NUM_CHAR);
    assign w_end_ev  = o_out_valid && (o_event_res == idnl_pkg::EV_ID_END ||
                                       o_event_res == idnl_pkg::EV_NUM_END);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready && !o_out_valid)
        else $error("Reset did not leave the block empty and ready.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_event_res) && $stable(o_line_number))
        else $error("A stalled result changed.");

    a_char_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_char_ev |-> o_token_length == '0 && o_error_code == idnl_pkg::ERR_NONE)
        else $error("A character result carries a length or an error.");

    a_end_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end_ev |-> o_char_out == 8'h00 &&
                     o_token_length <= idnl_pkg::LEN_W'(MAX_LEXEME))
        else $error("A token end carries a character or an excess length.");

    a_too_long_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end_ev && o_error_code == idnl_pkg::ERR_TOO_LONG |->
            o_token_length == idnl_pkg::LEN_W'(MAX_LEXEME))
        else $error("An over-long token was not reported at the length limit.");

endmodule

bind identifier_number_lexer_core idnl_checker #(
    .MAX_LEXEME (MAX_LEXEME)
) u_idnl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_event_res    (o_event_res),
    .o_char_out     (o_char_out),
    .o_token_length (o_token_length),
    .o_line_number  (o_line_number),
    .o_error_code   (o_error_code)
);

FILE: tb/tb_identifier_number_lexer_core.sv
`timescale 1ns / 1ps

module tb_identifier_number_lexer_core;
    import idnl_pkg::*;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [15:0] LINE_MAX  = 16'hFFFF;
    localparam int RANDOM_TOKEN_ITEMS = 1350;

    class token_scoreboard;
        t_result     pending_events[$];
        t_result     item_events[$];
        t_mode       mode;
        logic [15:0] line_no;
        int unsigned lex_len;
        bit          prev_us;
        bit          over;
        int          failures;

        function new();
            mode = MODE_IDLE;
            line_no = 16'd1;
            lex_len = 0;
            prev_us = 1'b0;
            over = 1'b0;
            failures = 0;
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function void push_event(t_event ev, logic [7:0] ch, int unsigned len, t_err err);
            t_result r;
            r.ev = ev;
            r.ch = ch;
            r.len = len[LEN_W-1:0];
            r.line = line_no;
            r.err = err;
            r.last = 1'b0;
            item_events.push_back(r);
        endfunction

        function void close_token(bit dbl);
            t_err err;
            err = ERR_NONE;
            if (over) begin
                err = ERR_TOO_LONG;
            end else if (dbl) begin
                err = ERR_DOUBLE_US;
            end else if (mode == MODE_IDENT && prev_us) begin
                err = ERR_TRAILING;
            end
            push_event((mode == MODE_IDENT) ? EV_ID_END : EV_NUM_END, 8'd0, lex_len, err);
            mode = MODE_IDLE;
            lex_len = 0;
            prev_us = 1'b0;
            over = 1'b0;
        endfunction

        function void keep_char(logic [7:0] c);
            if (lex_len < MAX_LEXEME_DEF) begin
                lex_len++;
                push_event((mode == MODE_IDENT) ? EV_ID_CHAR : EV_NUM_CHAR, c, 0, ERR_NONE);
            end else begin
                over = 1'b1;
            end
        endfunction

        function void idle_byte(logic [7:0] c);
            if (c == CH_NEWLINE) begin
                if (line_no != LINE_MAX) begin
                    line_no++;
                end
            end else if (c == CH_TILDE) begin
                mode = MODE_COMMENT;
            end else if (is_digit(c) || is_letter(c)) begin
                mode = is_digit(c) ? MODE_NUMBER : MODE_IDENT;
                lex_len = 0;
                prev_us = 1'b0;
                over = 1'b0;
                keep_char(c);
            end
        endfunction

        function int note_request(logic [7:0] c, logic eot);
            t_result r;
            item_events.delete();
            if (eot) begin
                if (mode == MODE_IDENT || mode == MODE_NUMBER) begin
                    close_token(1'b0);
                end
                mode = MODE_IDLE;
            end else if (mode == MODE_COMMENT) begin
                if (c == CH_NEWLINE) begin
                    mode = MODE_IDLE;
                    idle_byte(c);
                end
            end else if (mode == MODE_IDENT) begin
                if (c == CH_UNDERSCORE && prev_us) begin
                    keep_char(c);
                    close_token(1'b1);
                end else if (is_letter(c) || is_digit(c) || c == CH_UNDERSCORE) begin
                    keep_char(c);
                    prev_us = (c == CH_UNDERSCORE);
                end else begin
                    close_token(1'b0);
                    idle_byte(c);
                end
            end else if (mode == MODE_NUMBER) begin
                if (is_digit(c)) begin
                    keep_char(c);
                end else begin
                    close_token(1'b0);
                    idle_byte(c);
                end
            end else begin
                idle_byte(c);
            end
            foreach (item_events[i]) begin
                r = item_events[i];
                r.last = (i == item_events.size() - 1);
                pending_events.push_back(r);
            end
            return item_events.size();
        endfunction

        function int outstanding();
            return pending_events.size();
        endfunction

        function void report(string field, logic [15:0] expv, logic [15:0] actv);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expv, actv);
            failures++;
        endfunction

        function void check_result(logic [1:0] ev, logic [7:0] ch, logic [LEN_W-1:0] len,
                                   logic [LINE_W-1:0] line, logic [1:0] err, logic lst);
            t_result e;
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual event %0d char %0d",
                         $time, ev, ch);
                failures++;
                return;
            end
            e = pending_events.pop_front();
            if (ev !== e.ev) report("event", 16'(e.ev), 16'(ev));
            if (ch !== e.ch) report("char", 16'(e.ch), 16'(ch));
            if (len !== e.len) report("length", 16'(e.len), 16'(len));
            if (line !== e.line) report("line", e.line, line);
            if (err !== e.err) report("error", 16'(e.err), 16'(err));
            if (lst !== e.last) report("last", 16'(e.last), 16'(lst));
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [7:0]          i_char_in = 8'd0;
    logic                i_end_of_text = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [1:0]          o_event_res;
    logic [7:0]          o_char_out;
    logic [LEN_W-1:0]    o_token_length;
    logic [LINE_W-1:0]   o_line_number;
    logic [1:0]          o_error_code;
    logic                o_last;

    token_scoreboard sb = new();
    int  burst_left = 0;
    int  sent_items = 0;
    int  stall_pct = 0;
    int  stall_left = 0;

    identifier_number_lexer_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_char_in      (i_char_in),
        .i_end_of_text  (i_end_of_text),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_event_res    (o_event_res),
        .o_char_out     (o_char_out),
        .o_token_length (o_token_length),
        .o_line_number  (o_line_number),
        .o_error_code   (o_error_code),
        .o_last         (o_last)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_event_res, o_char_out, o_token_length, o_line_number,
                            o_error_code, o_last);
        end
        if (stall_left == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 30;
                2: stall_pct = 60;
                default: stall_pct = 85;
            endcase
            stall_left = $urandom_range(20, 300);
        end else begin
            stall_left--;
        end
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic logic [7:0] random_letter();
        logic [7:0] base;
        base = ($urandom_range(0, 1) != 0) ? CH_UPPER_A : CH_LOWER_A;
        return base + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] random_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] ident_tail();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return random_letter();
        if (r < 8) return random_digit();
        return CH_UNDERSCORE;
    endfunction

    task automatic send_item(input logic [7:0] c, input logic e);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 48);
        end
        if (burst_left > 0) burst_left--;
        i_in_valid <= 1'b1;
        i_char_in <= c;
        i_end_of_text <= e;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        void'(sb.note_request(c, e));
        sent_items++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_item(s[i], 1'b0);
        end
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
        burst_left = $urandom_range(1, 30);
    endtask

    task automatic random_token();
        int kind;
        int n;
        int r;
        kind = $urandom_range(0, 99);
        r = $urandom_range(0, 99);
        if (kind < 40) begin
            n = ($urandom_range(0, 99) < 4) ? $urandom_range(MAX_LEXEME_DEF - 4, MAX_LEXEME_DEF + 16)
                                             : $urandom_range(1, 12);
            send_item(random_letter(), 1'b0);
            for (int i = 1; i < n; i++) send_item(ident_tail(), 1'b0);
            if (r < 10) begin
                send_item(CH_UNDERSCORE, 1'b0);
                send_item(CH_UNDERSCORE, 1'b0);
            end else if (r < 20) begin
                send_item(CH_UNDERSCORE, 1'b0);
            end
        end else if (kind < 65) begin
            n = ($urandom_range(0, 99) < 4) ? $urandom_range(MAX_LEXEME_DEF - 4, MAX_LEXEME_DEF + 16)
                                             : $urandom_range(1, 10);
            for (int i = 0; i < n; i++) send_item(random_digit(), 1'b0);
        end else if (kind < 75) begin
            send_item(CH_TILDE, 1'b0);
            repeat ($urandom_range(0, 8)) send_item(8'($urandom_range(0, 255)), 1'b0);
            send_item(CH_NEWLINE, 1'b0);
        end else if (kind < 88) begin
            send_item(8'($urandom_range(0, 255)), 1'b0);
        end else if (kind < 93) begin
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end else begin
            send_item(CH_NEWLINE, 1'b0);
        end
        r = $urandom_range(0, 99);
        if (r < 45) begin
            send_item(CH_SPACE, 1'b0);
        end else if (r < 55) begin
            send_item(CH_TAB, 1'b0);
        end else if (r < 65) begin
            send_item(CH_NEWLINE, 1'b0);
        end else if (r >= 80) begin
            send_item(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    initial begin
        int start_items;
        bit drained;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_text("Az_9 ");
        send_text("Z__");
        send_text("a_\t");
        send_text("09z");
        send_item(8'h00, 1'b1);
        send_item(CH_TILDE, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(CH_NEWLINE, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h00, 1'b0);
        send_text("@`{/");
        send_item(8'hFF, 1'b1);
        send_text("7");
        send_item(8'h55, 1'b1);
        send_item(CH_TILDE, 1'b0);
        send_item(8'hAA, 1'b1);

        start_items = sent_items;
        drained = 1'b0;
        while (sent_items - start_items < RANDOM_TOKEN_ITEMS) begin
            random_token();
            if (!drained && sent_items - start_items >= RANDOM_TOKEN_ITEMS / 2) begin
                wait_for_results();
                drained = 1'b1;
            end
        end

        repeat (30) random_token();
        send_item(8'h00, 1'b1);

        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.failures == 0 && sb.outstanding() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
src/idnl_pkg.sv
src/idnl_scan.sv
src/idnl_res_fifo.sv
src/identifier_number_lexer_core.sv
src/idnl_checker.sv
tb/tb_identifier_number_lexer_core.sv
